### rtl/core/cfb_pkg.sv
// Shared types and constants for the command frame builder.
`default_nettype none

package cfb_pkg;

	// configuration port
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 16;
	localparam logic [15:0] MAX_PAYLOAD_RST = 16'd1024;

	// command queue between front and back
	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// request types
	localparam logic REQ_START = 1'b0;
	localparam logic REQ_DATA  = 1'b1;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_HEAD_BYTE    = 2'd0,
		REG_LONG_VERSION = 2'd1,
		REG_MAX_PAYLOAD  = 2'd2
	} cfg_reg_t;

	// configuration seen by the front
	typedef struct packed {
		logic [7:0]  long_version;
		logic [15:0] max_payload;
	} cfg_t;

	// one queued command: a frame start or a payload byte
	typedef struct packed {
		logic        is_start;
		logic        err;       // start rejected, length over maximum
		logic        is_long;   // two-byte length and index
		logic        closes;    // start with empty payload, or final payload byte
		logic [7:0]  version;
		logic [15:0] len;
		logic [7:0]  src;
		logic [7:0]  tgt;
		logic [7:0]  cmd;
		logic [15:0] idx;
		logic [7:0]  data;
	} cmd_t;

	// byte being emitted by the back end; PH_FIRST means take a fresh command
	typedef enum logic [3:0] {
		PH_FIRST,
		PH_HEAD,
		PH_VER,
		PH_LENL,
		PH_LENH,
		PH_SRC,
		PH_TGT,
		PH_CMD,
		PH_IDXL,
		PH_IDXH,
		PH_DATA,
		PH_CKL,
		PH_CKH,
		PH_ERR
	} phase_t;

endpackage

`default_nettype wire

### rtl/core/cfb_front.sv
// Front end: accepts input words, tracks the open frame and queues commands.
`default_nettype none

module cfb_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire cfb_pkg::cfg_t cfg,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire logic          req_type,
	input  wire logic [7:0]    version,
	input  wire logic [15:0]   payload_len,
	input  wire logic [7:0]    source_id,
	input  wire logic [7:0]    target_id,
	input  wire logic [7:0]    command,
	input  wire logic [15:0]   data_index,
	input  wire logic [7:0]    data_byte,
	output logic               push,
	output cfb_pkg::cmd_t      push_cmd,
	input  wire logic          q_ready
);
	import cfb_pkg::*;

	logic        open_q;
	logic [15:0] left_q;
	logic        accept;
	logic        too_long;

	assign in_ready = q_ready;
	assign accept   = in_valid && in_ready;
	assign too_long = payload_len > cfg.max_payload;

	// queue starts always, payload words only inside an open frame
	assign push = accept && ((req_type == REQ_START) || open_q);

	// build the command
	always_comb begin
		push_cmd          = '0;
		push_cmd.is_start = (req_type == REQ_START);
		push_cmd.err      = too_long;
		push_cmd.is_long  = (version == cfg.long_version);
		push_cmd.closes   = (req_type == REQ_START) ? (payload_len == 16'd0)
		                                            : (left_q == 16'd1);
		push_cmd.version  = version;
		push_cmd.len      = payload_len;
		push_cmd.src      = source_id;
		push_cmd.tgt      = target_id;
		push_cmd.cmd      = command;
		push_cmd.idx      = data_index;
		push_cmd.data     = data_byte;
	end

	// track frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= 1'b0;
			left_q <= 16'd0;
		end else if (accept) begin
			if (req_type == REQ_START) begin
				open_q <= !too_long && (payload_len != 16'd0);
				left_q <= too_long ? 16'd0 : payload_len;
			end else if (open_q) begin
				open_q <= (left_q != 16'd1);
				left_q <= left_q - 16'd1;
			end
		end
	end

endmodule

`default_nettype wire

### rtl/core/cfb_queue.sv
// Short command queue decoupling front and back ends.
`default_nettype none

module cfb_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire cfb_pkg::cmd_t push_cmd,
	output logic               q_ready,
	output logic               q_valid,
	output cfb_pkg::cmd_t      q_cmd,
	input  wire logic          pop
);
	import cfb_pkg::*;

	cmd_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QCNT_W-1:0] count_q;

	assign q_ready = (count_q != QCNT_W'(QUEUE_DEPTH));
	assign q_valid = (count_q != '0);
	assign q_cmd   = mem_q[rd_q];

	// store entries
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_cmd;
		end
	end

	// advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QUEUE_DEPTH))
		else $error("queue count beyond depth");

	a_count_inc: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (count_q == $past(count_q) + 1'b1))
		else $error("queue count did not follow a push");
`endif

endmodule

`default_nettype wire

### rtl/core/cfb_back.sv
// Back end: serialises queued commands into frame bytes with checksum.
`default_nettype none

module cfb_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic [7:0]    head_byte,
	input  wire logic          q_valid,
	input  wire cfb_pkg::cmd_t q_cmd,
	output logic               pop,
	output logic               out_valid,
	input  wire logic          out_ready,
	output logic [7:0]         out_byte,
	output logic               last,
	output logic               error
);
	import cfb_pkg::*;

	phase_t      phase_q;
	phase_t      phase_d;
	phase_t      kind;
	phase_t      after;
	logic [15:0] sum_q;
	logic [15:0] chk;
	logic        fire;
	logic        summed;
	logic [7:0]  byte_d;
	logic        out_valid_q;
	logic [7:0]  byte_q;
	logic        last_q;
	logic        err_q;

	assign out_valid = out_valid_q;
	assign out_byte  = byte_q;
	assign last      = last_q;
	assign error     = err_q;
	assign chk       = ~sum_q;
	assign fire      = q_valid && (!out_valid_q || out_ready);

	// hold the phase register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_FIRST;
		end else begin
			phase_q <= phase_d;
		end
	end

	// pick the current byte and the one after it
	always_comb begin
		if (phase_q != PH_FIRST) begin
			kind = phase_q;
		end else if (!q_cmd.is_start) begin
			kind = PH_DATA;
		end else if (q_cmd.err) begin
			kind = PH_ERR;
		end else begin
			kind = PH_HEAD;
		end

		case (kind)
			PH_HEAD: after = PH_VER;
			PH_VER:  after = PH_LENL;
			PH_LENL: after = q_cmd.is_long ? PH_LENH : PH_SRC;
			PH_LENH: after = PH_SRC;
			PH_SRC:  after = PH_TGT;
			PH_TGT:  after = PH_CMD;
			PH_CMD:  after = PH_IDXL;
			PH_IDXL: after = q_cmd.is_long ? PH_IDXH
			                               : (q_cmd.closes ? PH_CKL : PH_FIRST);
			PH_IDXH: after = q_cmd.closes ? PH_CKL : PH_FIRST;
			PH_DATA: after = q_cmd.closes ? PH_CKL : PH_FIRST;
			PH_CKL:  after = PH_CKH;
			default: after = PH_FIRST;
		endcase

		summed = 1'b0;
		case (kind)
			PH_HEAD: byte_d = head_byte;
			PH_VER:  byte_d = q_cmd.version;
			PH_LENL: begin byte_d = q_cmd.len[7:0];  summed = 1'b1; end
			PH_LENH: begin byte_d = q_cmd.len[15:8]; summed = 1'b1; end
			PH_SRC:  begin byte_d = q_cmd.src;       summed = 1'b1; end
			PH_TGT:  begin byte_d = q_cmd.tgt;       summed = 1'b1; end
			PH_CMD:  begin byte_d = q_cmd.cmd;       summed = 1'b1; end
			PH_IDXL: begin byte_d = q_cmd.idx[7:0];  summed = 1'b1; end
			PH_IDXH: begin byte_d = q_cmd.idx[15:8]; summed = 1'b1; end
			PH_DATA: begin byte_d = q_cmd.data;      summed = 1'b1; end
			PH_CKL:  byte_d = chk[7:0];
			PH_CKH:  byte_d = chk[15:8];
			default: byte_d = 8'd0;
		endcase

		phase_d = phase_q;
		pop     = 1'b0;
		if (fire) begin
			phase_d = after;
			pop     = (after == PH_FIRST);
		end
	end

	// keep the running sum; a frame head clears it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= 16'd0;
		end else if (fire) begin
			if (kind == PH_HEAD) begin
				sum_q <= 16'd0;
			end else if (summed) begin
				sum_q <= sum_q + {8'd0, byte_d};
			end
		end
	end

	// output register: load when empty or being drained
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			byte_q <= byte_d;
			last_q <= (kind == PH_CKH) || (kind == PH_ERR);
			err_q  <= (kind == PH_ERR);
		end
	end

`ifndef SYNTH
	a_mid_frame_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q != PH_FIRST) |-> q_valid)
		else $error("command left the queue in the middle of its bytes");

	a_err_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && err_q) |-> (last_q && (byte_q == 8'd0)))
		else $error("error word without last or with non-zero byte");
`endif

endmodule

`default_nettype wire

### rtl/core/command_frame_builder_core.sv
// Top level of the command frame builder: configuration registers and wiring.
//
// Usage:
//   Input channel (in_valid/in_ready) takes one word per request. req_type 0
//   starts a frame from the header fields; req_type 1 carries one payload byte.
//   Payload words that arrive with no frame open are taken and dropped.
//   Output channel (out_valid/out_ready) gives one frame byte per word, with
//   last on the checksum high byte and last plus error on a rejected start.
//   Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) is always
//   ready; write it only while no frame bytes are pending.
// Timing:
//   A taken word goes through the command queue and the back end's output
//   register, in that order, before its first byte appears. A rejected start
//   yields one byte; any other start yields 7 to 11 bytes at one per cycle
//   while out_ready holds; a payload word yields one byte, or three on the
//   final one. Sustained rate is one output byte per cycle while out_ready
//   holds, set by the single output register of the back end; payload words
//   therefore stream at one per cycle. A two-entry command queue lets the
//   input side keep accepting while the back end works through a header.
// Reset and stall:
//   arst_n clears the queue, frame state, output valid and configuration
//   (head byte 0, long version 0, maximum payload 1024). A stalled receiver
//   holds the output word; the queue fills and then in_ready drops.
`default_nettype none

module command_frame_builder_core (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [cfb_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [cfb_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire logic                            req_type,
	input  wire logic [7:0]                      version,
	input  wire logic [15:0]                     payload_len,
	input  wire logic [7:0]                      source_id,
	input  wire logic [7:0]                      target_id,
	input  wire logic [7:0]                      command,
	input  wire logic [15:0]                     data_index,
	input  wire logic [7:0]                      data_byte,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic [7:0]                           out_byte,
	output logic                                 last,
	output logic                                 error
);
	import cfb_pkg::*;

	logic [7:0]  head_q;
	logic [7:0]  long_q;
	logic [15:0] max_q;
	cfg_t        cfg;
	logic        push;
	cmd_t        push_cmd;
	logic        q_ready;
	logic        q_valid;
	cmd_t        q_cmd;
	logic        pop;

	assign cfg_ready        = 1'b1;
	assign cfg.long_version = long_q;
	assign cfg.max_payload  = max_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= 8'd0;
			long_q <= 8'd0;
			max_q  <= MAX_PAYLOAD_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_HEAD_BYTE:    head_q <= cfg_data[7:0];
				REG_LONG_VERSION: long_q <= cfg_data[7:0];
				REG_MAX_PAYLOAD:  max_q  <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	cfb_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.req_type    (req_type),
		.version     (version),
		.payload_len (payload_len),
		.source_id   (source_id),
		.target_id   (target_id),
		.command     (command),
		.data_index  (data_index),
		.data_byte   (data_byte),
		.push        (push),
		.push_cmd    (push_cmd),
		.q_ready     (q_ready)
	);

	cfb_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.q_ready  (q_ready),
		.q_valid  (q_valid),
		.q_cmd    (q_cmd),
		.pop      (pop)
	);

	cfb_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_byte (head_q),
		.q_valid   (q_valid),
		.q_cmd     (q_cmd),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_byte  (out_byte),
		.last      (last),
		.error     (error)
	);

endmodule

`default_nettype wire

### bench/tb_command_frame_builder_core.sv
// Self-checking testbench for the command frame builder core: predicted frame bytes vs output.
module tb_command_frame_builder_core;
	timeunit 1ns;
	timeprecision 1ps;

	import cfb_pkg::*;

	localparam int QUIET_LIMIT   = 500;
	localparam int SETTLE_CYCLES = 8;
	// index beyond the register map; a write there changes nothing
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

	// one request word on the input channel
	typedef struct {
		logic        req;
		logic [7:0]  ver;
		logic [15:0] len;
		logic [7:0]  src;
		logic [7:0]  tgt;
		logic [7:0]  cmd;
		logic [15:0] idx;
		logic [7:0]  data;
	} req_word_t;

	// one byte of a frame as it should leave the block
	typedef struct {
		logic [7:0] value;
		logic       last;
		logic       err;
	} frame_byte_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  in_valid;
	logic                  in_ready;
	logic                  req_type;
	logic [7:0]            version;
	logic [15:0]           payload_len;
	logic [7:0]            source_id;
	logic [7:0]            target_id;
	logic [7:0]            command;
	logic [15:0]           data_index;
	logic [7:0]            data_byte;
	logic                  out_valid;
	logic                  out_ready;
	logic [7:0]            out_byte;
	logic                  last;
	logic                  error;

	// predictor copy of registers and frame state
	logic [7:0]  cfg_head;
	logic [7:0]  cfg_long_version;
	logic [15:0] cfg_max_payload;
	logic        frame_open;
	logic [15:0] bytes_left;
	logic [15:0] running_sum;

	frame_byte_t pending_bytes[$];
	int          mismatch_count = 0;
	int          quiet_cycles = 0;
	int          stall_left = 0;
	bit          idle_on = 1'b1;

	command_frame_builder_core dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.req_type    (req_type),
		.version     (version),
		.payload_len (payload_len),
		.source_id   (source_id),
		.target_id   (target_id),
		.command     (command),
		.data_index  (data_index),
		.data_byte   (data_byte),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_byte    (out_byte),
		.last        (last),
		.error       (error)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// report one mismatch and count it
	task automatic report_mismatch(input string what, input int got, input int want);
		$display("MISMATCH %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
		mismatch_count++;
	endtask

	// queue one expected frame byte
	task automatic push_byte(input logic [7:0] value, input logic lst, input logic err);
		frame_byte_t b;
		b.value = value;
		b.last  = lst;
		b.err   = err;
		pending_bytes.push_back(b);
	endtask

	// queue a byte that counts towards the checksum
	task automatic push_summed(input logic [7:0] value);
		running_sum = running_sum + 16'(value);
		push_byte(value, 1'b0, 1'b0);
	endtask

	// queue the inverted sum, low byte first, and close the frame
	task automatic close_frame();
		logic [15:0] ck;
		ck = ~running_sum;
		push_byte(ck[7:0], 1'b0, 1'b0);
		push_byte(ck[15:8], 1'b1, 1'b0);
		frame_open  = 1'b0;
		bytes_left  = '0;
		running_sum = '0;
	endtask

	// work out the frame bytes caused by one accepted word
	task automatic predict_frame_bytes(input req_word_t w);
		logic lng;
		if (w.req == REQ_START) begin
			lng         = (w.ver == cfg_long_version);
			frame_open  = 1'b0;
			bytes_left  = '0;
			running_sum = '0;
			if (w.len > cfg_max_payload) begin
				push_byte(8'h00, 1'b1, 1'b1);
			end else begin
				push_byte(cfg_head, 1'b0, 1'b0);
				push_byte(w.ver, 1'b0, 1'b0);
				push_summed(w.len[7:0]);
				if (lng) push_summed(w.len[15:8]);
				push_summed(w.src);
				push_summed(w.tgt);
				push_summed(w.cmd);
				push_summed(w.idx[7:0]);
				if (lng) push_summed(w.idx[15:8]);
				if (w.len == 16'd0) begin
					close_frame();
				end else begin
					frame_open = 1'b1;
					bytes_left = w.len;
				end
			end
		end else if (frame_open) begin
			push_summed(w.data);
			bytes_left = bytes_left - 16'd1;
			if (bytes_left == 16'd0) close_frame();
		end
	endtask

	// check each output word against the oldest expected byte
	always @(posedge clk) begin
		frame_byte_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_bytes.size() == 0) begin
				report_mismatch("byte with nothing due", int'(out_byte), 0);
			end else begin
				want = pending_bytes.pop_front();
				if (out_byte !== want.value)
					report_mismatch("out_byte", int'(out_byte), int'(want.value));
				if (last !== want.last)
					report_mismatch("last", int'(last), int'(want.last));
				if (error !== want.err)
					report_mismatch("error", int'(error), int'(want.err));
			end
		end
	end

	// stall the output side in random bursts
	always @(negedge clk) begin
		if (!idle_on) begin
			stall_left <= 0;
			out_ready  <= 1'b1;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			out_ready  <= 1'b0;
		end else if ($urandom_range(0, 4) == 0) begin
			stall_left <= $urandom_range(0, 9);
			out_ready  <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// end the run when nothing has moved for too long
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("TIMEOUT: no word moved for %0d cycles", QUIET_LIMIT);
			$display("DONE: errors detected");
			$finish;
		end
	end

	function automatic req_word_t random_word(input logic req);
		req_word_t w;
		w.req  = req;
		w.ver  = 8'($urandom_range(0, 255));
		w.len  = 16'($urandom_range(0, 65535));
		w.src  = 8'($urandom_range(0, 255));
		w.tgt  = 8'($urandom_range(0, 255));
		w.cmd  = 8'($urandom_range(0, 255));
		w.idx  = 16'($urandom_range(0, 65535));
		w.data = 8'($urandom_range(0, 255));
		return w;
	endfunction

	function automatic req_word_t start_word(input logic [7:0] ver, input logic [15:0] len,
			input logic [7:0] src, input logic [7:0] tgt, input logic [7:0] cmd,
			input logic [15:0] idx);
		req_word_t w;
		w     = random_word(REQ_START);
		w.ver = ver;
		w.len = len;
		w.src = src;
		w.tgt = tgt;
		w.cmd = cmd;
		w.idx = idx;
		return w;
	endfunction

	function automatic req_word_t data_word(input logic [7:0] value);
		req_word_t w;
		w      = random_word(REQ_DATA);
		w.data = value;
		return w;
	endfunction

	// present one word, hold it until taken, then predict its bytes
	task automatic send_word(input req_word_t w);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat ($urandom_range(0, 9)) @(negedge clk);
		end
		@(negedge clk);
		in_valid    <= 1'b1;
		req_type    <= w.req;
		version     <= w.ver;
		payload_len <= w.len;
		source_id   <= w.src;
		target_id   <= w.tgt;
		command     <= w.cmd;
		data_index  <= w.idx;
		data_byte   <= w.data;
		do @(posedge clk); while (!in_ready);
		predict_frame_bytes(w);
	endtask

	// drop valid and wait until every expected byte has come out
	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_bytes.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// write one register while the block is idle
	task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
		wait_drained();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_HEAD_BYTE:    cfg_head         = value[7:0];
			REG_LONG_VERSION: cfg_long_version = value[7:0];
			REG_MAX_PAYLOAD:  cfg_max_payload  = value;
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// start a frame in short or long format, then send some of its payload
	task automatic send_frame(input logic [15:0] len, input bit lng, input int n_data);
		req_word_t w;
		w     = random_word(REQ_START);
		w.len = len;
		w.ver = lng ? cfg_long_version : cfg_long_version + 8'($urandom_range(1, 255));
		send_word(w);
		repeat (n_data) send_word(random_word(REQ_DATA));
	endtask

	// mostly whole frames with random content, plus strays, abandons and oversize starts
	task automatic random_frames(input int frames, input int max_len, input bit allow_idle);
		int kind;
		int len;
		for (int i = 0; i < frames; i++) begin
			idle_on = allow_idle && ($urandom_range(0, 3) != 0);
			kind    = $urandom_range(0, 9);
			len     = $urandom_range(0, max_len);
			if (len > cfg_max_payload) len = int'(cfg_max_payload);
			if (kind == 0)
				send_word(random_word(REQ_DATA));
			else if (kind == 1 && cfg_max_payload != 16'hFFFF)
				send_frame(16'($urandom_range(int'(cfg_max_payload) + 1, 65535)),
					1'($urandom_range(0, 1)), 0);
			else if (kind == 2 && len > 1)
				send_frame(16'(len), 1'($urandom_range(0, 1)), $urandom_range(0, len - 1));
			else
				send_frame(16'(len), 1'($urandom_range(0, 1)), len);
		end
	endtask

	// reset register values: long format on version 0, maximum 1024
	task automatic test_reset_values();
		send_word(start_word(8'h00, 16'h0000, 8'h00, 8'hFF, 8'h00, 16'hFFFF));
		send_word(start_word(8'h80, 16'h0002, 8'hFF, 8'h00, 8'hFF, 16'h0000));
		send_word(data_word(8'hFF));
		send_word(data_word(8'h00));
		// payload with no frame open is dropped
		send_word(data_word(8'hAA));
		send_word(start_word(8'h01, 16'd1025, 8'h11, 8'h22, 8'h33, 16'h4455));
		send_word(data_word(8'h55));
		// longest accepted length, then abandon it with a fresh start
		send_word(start_word(8'hFF, 16'd1024, 8'h12, 8'h34, 8'h56, 16'h789A));
		send_word(data_word(8'h3C));
		send_word(start_word(8'h00, 16'h0001, 8'hA5, 8'h5A, 8'hC3, 16'h8001));
		send_word(data_word(8'hC3));
	endtask

	// registers at their extremes, and a write to the unused index
	task automatic test_register_extremes();
		write_register(REG_HEAD_BYTE, 16'hFFFF);
		write_register(REG_LONG_VERSION, 16'hFFFF);
		write_register(REG_MAX_PAYLOAD, 16'h0000);
		send_word(start_word(8'hFF, 16'h0000, 8'h5A, 8'hA5, 8'h81, 16'h1234));
		send_word(start_word(8'h7F, 16'h0001, 8'h01, 8'h02, 8'h03, 16'h0004));
		send_word(data_word(8'h99));
		write_register(REG_MAX_PAYLOAD, 16'hFFFF);
		send_word(start_word(8'hFF, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 16'h8000));
		send_word(data_word(8'h01));
		send_word(data_word(8'h80));
		send_word(start_word(8'h00, 16'h0003, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF));
		repeat (3) send_word(data_word(8'hFF));
		write_register(REG_SPARE, 16'($urandom_range(0, 65535)));
		send_word(start_word(8'hFF, 16'h0000, 8'h00, 8'h00, 8'h00, 16'h0000));
	endtask

	// random traffic under a tight and a roomy maximum
	task automatic test_random_settings();
		write_register(REG_HEAD_BYTE, 16'($urandom_range(0, 65535)));
		write_register(REG_LONG_VERSION, 16'($urandom_range(0, 255)));
		write_register(REG_MAX_PAYLOAD, 16'd6);
		random_frames(12, 8, 1'b1);
		write_register(REG_HEAD_BYTE, 16'h00A5);
		write_register(REG_LONG_VERSION, 16'($urandom_range(0, 255)));
		write_register(REG_MAX_PAYLOAD, 16'd1024);
		random_frames(10, 10, 1'b1);
	endtask

	// hold the sender off until every expected byte has come out
	task automatic test_sender_pause();
		random_frames(3, 5, 1'b1);
		wait_drained();
		random_frames(3, 5, 1'b1);
	endtask

	// back-to-back words with the receiver always ready
	task automatic test_streaming();
		random_frames(12, 6, 1'b0);
	endtask

	initial begin
		arst_n           = 1'b0;
		cfg_valid        = 1'b0;
		cfg_index        = REG_HEAD_BYTE;
		cfg_data         = '0;
		in_valid         = 1'b0;
		req_type         = REQ_START;
		version          = '0;
		payload_len      = '0;
		source_id        = '0;
		target_id        = '0;
		command          = '0;
		data_index       = '0;
		data_byte        = '0;
		out_ready        = 1'b0;
		cfg_head         = 8'h00;
		cfg_long_version = 8'h00;
		cfg_max_payload  = MAX_PAYLOAD_RST;
		frame_open       = 1'b0;
		bytes_left       = '0;
		running_sum      = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_values();
		test_register_extremes();
		test_random_settings();
		test_sender_pause();
		test_streaming();

		wait_drained();
		if (mismatch_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
